@@ hdl/rgb_led_serial_bit_encoder_unit_assert.svh @@
// assertion macros shared by the encoder modules
// expects clk and rst in the scope of each use
`ifndef RGB_LED_SERIAL_BIT_ENCODER_UNIT_ASSERT_SVH
`define RGB_LED_SERIAL_BIT_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RGBENC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RGBENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rgbenc_pkg.sv @@
// shared types, register codes and the gamma table generator
// used by every module of the rgb led serial bit encoder
`default_nettype none

package rgbenc_pkg;

  // one request: pixel or frame end
  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
  } in_item_t;

  // one duty slot
  typedef struct packed {
    logic [7:0] duty;
    logic       last;
  } out_item_t;

  // configuration register file
  typedef struct packed {
    logic [7:0] high_duty;
    logic [7:0] low_duty;
    logic [6:0] reset_slots;
    logic       brightness_enable;
  } cfg_t;

  // colour word handed from the scaler to the serialiser
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [23:0] word;
  } word_req_t;

  localparam logic KIND_PIXEL     = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic [1:0] REG_HIGH_DUTY   = 2'd0;
  localparam logic [1:0] REG_LOW_DUTY    = 2'd1;
  localparam logic [1:0] REG_RESET_SLOTS = 2'd2;
  localparam logic [1:0] REG_BRIGHT_EN   = 2'd3;

  localparam logic [7:0] HIGH_DUTY_RST   = 8'd64;
  localparam logic [7:0] LOW_DUTY_RST    = 8'd32;
  localparam logic [6:0] RESET_SLOTS_RST = 7'd50;
  localparam logic       BRIGHT_EN_RST   = 1'b1;

  localparam logic [6:0] PIXEL_SLOTS = 7'd24;
  localparam logic [6:0] MAX_SLOTS   = 7'd64;

  // widest supported gamma fraction
  localparam int MaxFracBits = 24;

  // largest v with v^5 * 255^11 <= b^11 * 2^(5*frac), elaboration only
  function automatic logic [MaxFracBits:0] gamma_entry(input int b, input int frac);
    logic [255:0]         rhs;
    logic [255:0]         lhs;
    logic [MaxFracBits:0] lo;
    logic [MaxFracBits:0] hi;
    logic [MaxFracBits:0] mid;
    rhs = 256'd1;
    for (int i = 0; i < 11; i++) begin
      rhs = rhs * 256'(b);
    end
    rhs = rhs << (5 * frac);
    lo = '0;
    hi = (MaxFracBits + 1)'(1) << frac;
    for (int it = 0; it < MaxFracBits + 2; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1'b1) >> 1);
        lhs = 256'(mid);
        for (int i = 0; i < 4; i++) begin
          lhs = lhs * 256'(mid);
        end
        for (int i = 0; i < 11; i++) begin
          lhs = lhs * 256'd255;
        end
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1'b1;
        end
      end
    end
    return lo;
  endfunction

  // frame end length, kept within one to the maximum
  function automatic logic [6:0] clamp_slots(input logic [6:0] slots);
    logic [6:0] n;
    n = slots;
    if (slots == 7'd0) begin
      n = 7'd1;
    end else if (slots > MAX_SLOTS) begin
      n = MAX_SLOTS;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rgbenc_scale.sv @@
// two-stage gamma scaler: table lookup, then three colour multiplies
// depends on rgbenc_pkg and the assertion header
`default_nettype none

module rgbenc_scale #(
  parameter int GAMMA_FRAC_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  rgbenc_pkg::in_item_t     item,
  input  wire                      brightness_enable,
  output rgbenc_pkg::word_req_t    word_out,
  input  wire                      word_ready
);
  import rgbenc_pkg::*;

  `include "rgb_led_serial_bit_encoder_unit_assert.svh"

  localparam int GW = GAMMA_FRAC_BITS + 1;
  localparam int PW = GW + 8;
  localparam logic [GW-1:0] GainOne = GW'(1) << GAMMA_FRAC_BITS;

  // gamma table, constant per build
  logic [GW-1:0] gamma_lut [256];

  for (genvar b = 0; b < 256; b++) begin : g_lut
    localparam logic [MaxFracBits:0] Entry = gamma_entry(b, GAMMA_FRAC_BITS);
    assign gamma_lut[b] = Entry[GW-1:0];
  end

  // stage 1: captured request and its gain
  logic          v1;
  logic          kind1;
  logic [7:0]    red1;
  logic [7:0]    green1;
  logic [7:0]    blue1;
  logic [GW-1:0] gain1;

  // stage 2: scaled grb word waiting for the serialiser
  logic          v2;
  logic          kind2;
  logic [23:0]   word2;

  logic          take2;
  logic          move1;
  logic          accept;
  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_g;
  logic [PW-1:0] prod_b;

  assign take2  = !v2 || word_ready;
  assign move1  = !v1 || take2;
  assign busy   = !move1;
  assign accept = start && move1;

  // stage 1 capture, gain forced to unity when scaling is off
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (move1) begin
      v1 <= start;
    end
    if (accept) begin
      kind1  <= item.kind;
      red1   <= item.red;
      green1 <= item.green;
      blue1  <= item.blue;
      gain1  <= brightness_enable ? gamma_lut[item.brightness] : GainOne;
    end
  end

  // colour times gain, truncated back to eight bits
  assign prod_r = PW'(red1) * PW'(gain1);
  assign prod_g = PW'(green1) * PW'(gain1);
  assign prod_b = PW'(blue1) * PW'(gain1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (take2) begin
      v2 <= v1;
    end
    if (take2 && v1) begin
      kind2 <= kind1;
      word2 <= {prod_g[GAMMA_FRAC_BITS +: 8], prod_r[GAMMA_FRAC_BITS +: 8],
                prod_b[GAMMA_FRAC_BITS +: 8]};
    end
  end

  assign word_out.valid = v2;
  assign word_out.kind  = kind2;
  assign word_out.word  = word2;

  // checks
  `RGBENC_ASSERT_NOW(a_busy_means_full, busy, v1 && v2 && !word_ready, "busy without a full pipe")
  `RGBENC_ASSERT_NEXT(a_stage2_holds, v2 && !word_ready, v2 && $stable(word2) && $stable(kind2), "stalled word changed")
  `RGBENC_ASSERT_NEXT(a_stage1_holds, v1 && !take2, v1 && $stable(gain1), "stalled stage 1 changed")

endmodule

`default_nettype wire

@@ hdl/rgbenc_ser.sv @@
// serialiser: turns a colour word or frame end into one duty slot per cycle
// depends on rgbenc_pkg and the assertion header
`default_nettype none

module rgbenc_ser (
  input  wire                      clk,
  input  wire                      rst,
  input  rgbenc_pkg::cfg_t         cfg,
  input  rgbenc_pkg::word_req_t    word_in,
  output logic                     word_ready,
  output logic                     result_strobe,
  output rgbenc_pkg::out_item_t    result
);
  import rgbenc_pkg::*;

  `include "rgb_led_serial_bit_encoder_unit_assert.svh"

  logic        active;
  logic        mode;
  logic [23:0] shift;
  logic [6:0]  remaining;
  logic        last_slot;
  logic        load;

  assign last_slot  = active && (remaining == 7'd1);
  assign word_ready = !active || last_slot;
  assign load       = word_in.valid && word_ready;

  // slot counter and bit shifter, reloaded straight after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      remaining <= '0;
    end else if (load) begin
      active    <= 1'b1;
      remaining <= (word_in.kind == KIND_FRAME_END) ? clamp_slots(cfg.reset_slots)
                                                    : PIXEL_SLOTS;
    end else if (active) begin
      remaining <= remaining - 7'd1;
      if (last_slot) begin
        active <= 1'b0;
      end
    end
    if (load) begin
      mode  <= word_in.kind;
      shift <= word_in.word;
    end else if (active) begin
      shift <= {shift[22:0], 1'b0};
    end
  end

  // duty selection, msb first
  always_comb begin
    result.duty = (mode == KIND_FRAME_END) ? 8'd0
                : (shift[23] ? cfg.high_duty : cfg.low_duty);
    result.last = last_slot;
  end
  assign result_strobe = active;

  // checks
  `RGBENC_ASSERT_NOW(a_count_range, active, remaining >= 7'd1 && remaining <= MAX_SLOTS, "slot count out of range")
  `RGBENC_ASSERT_NEXT(a_pixel_load, load && word_in.kind == KIND_PIXEL, active && remaining == PIXEL_SLOTS, "pixel load miscounted")
  `RGBENC_ASSERT_NEXT(a_idle_after_last, last_slot && !word_in.valid, !active, "slots after the last one")

endmodule

`default_nettype wire

@@ hdl/rgb_led_serial_bit_encoder_unit.sv @@
// rgb led serial bit encoder: config registers, gamma scaler and serialiser
// depends on rgbenc_pkg, rgbenc_scale and rgbenc_ser
//
// Usage: a request is taken on a clock edge where start is high and busy
// is low; item carries either a pixel (red, green, blue, brightness) or a
// frame end. A pixel gives 24 duty slots in green, red, blue order, msb
// first, high_duty for a one and low_duty for a zero, colours optionally
// scaled by the gamma 2.2 brightness table. A frame end gives reset_slots
// zero slots (one to 64). Each slot sits on result for one cycle with
// result_strobe high; result.last marks the final slot of a request.
// A request passes both scaler stages and then loads into the serialiser
// when it is idle or on the last slot of the previous request. The
// serialiser emits one slot per cycle while it holds a request; the scaler
// holds up to two further requests, so slots of back-to-back requests
// follow without a gap. The receiver cannot stall; busy rises only while
// both scaler stages are full. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle; the user must keep to
// this, as the block does not enforce it. Synchronous reset empties the
// pipe and restores the register defaults; the gamma table is constant.
`default_nettype none

module rgb_led_serial_bit_encoder_unit #(
  parameter int GAMMA_FRAC_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  rgbenc_pkg::in_item_t   item,
  input  wire                    cfg_we,
  input  wire  [1:0]             cfg_index,
  input  wire  [7:0]             cfg_data,
  output logic                   result_strobe,
  output rgbenc_pkg::out_item_t  result
);
  import rgbenc_pkg::*;

  cfg_t      cfg;
  word_req_t word_req;
  logic      word_ready;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_duty         <= HIGH_DUTY_RST;
      cfg.low_duty          <= LOW_DUTY_RST;
      cfg.reset_slots       <= RESET_SLOTS_RST;
      cfg.brightness_enable <= BRIGHT_EN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_DUTY:   cfg.high_duty         <= cfg_data;
        REG_LOW_DUTY:    cfg.low_duty          <= cfg_data;
        REG_RESET_SLOTS: cfg.reset_slots       <= cfg_data[6:0];
        REG_BRIGHT_EN:   cfg.brightness_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // gamma scaling stages
  rgbenc_scale #(
    .GAMMA_FRAC_BITS(GAMMA_FRAC_BITS)
  ) u_scale (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .item             (item),
    .brightness_enable(cfg.brightness_enable),
    .word_out         (word_req),
    .word_ready       (word_ready)
  );

  // slot serialiser
  rgbenc_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .word_in      (word_req),
    .word_ready   (word_ready),
    .result_strobe(result_strobe),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking bench for rgb_led_serial_bit_encoder_unit: gamma scaling,
// bit slot expansion and frame end latch slots, checked slot by slot
// depends on rgbenc_pkg and the encoder rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbenc_pkg::*;

  localparam int GammaFrac  = 16;
  localparam int ClkHalf    = 10;
  localparam int RandPhases = 8;
  localparam int PhaseReqs  = 20;
  localparam int MaxFaultReports = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   item = '0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_HIGH_DUTY;
  logic [7:0] cfg_data = 8'd0;
  logic       result_strobe;
  out_item_t  result;

  rgb_led_serial_bit_encoder_unit #(
    .GAMMA_FRAC_BITS(GammaFrac)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_strobe(result_strobe),
    .result       (result)
  );

  // 50 MHz clock
  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // bench copy of the register file and the gamma curve
  logic [7:0]         one_duty   = HIGH_DUTY_RST;
  logic [7:0]         zero_duty  = LOW_DUTY_RST;
  logic [6:0]         latch_slots = RESET_SLOTS_RST;
  logic               gamma_on   = BRIGHT_EN_RST;
  logic [GammaFrac:0] gamma_lut [0:255];

  in_item_t  requests_pending [$];
  out_item_t duty_slots_due [$];
  int idle_pct = 0;
  int faults = 0;
  int requests_taken = 0;
  int frame_ends_taken = 0;
  int slots_checked = 0;

  // largest v with v^5 * 255^11 <= idx^11 * 2^(5*frac), built msb first
  function automatic logic [GammaFrac:0] gamma_point(input int idx);
    logic [255:0]       bound;
    logic [255:0]       trial;
    logic [GammaFrac:0] v;
    logic [GammaFrac:0] cand;
    bound = 256'd1;
    for (int i = 0; i < 11; i++) begin
      bound = bound * 256'(idx);
    end
    bound = bound << (5 * GammaFrac);
    v = '0;
    for (int bitpos = GammaFrac; bitpos >= 0; bitpos--) begin
      cand = v;
      cand[bitpos] = 1'b1;
      trial = 256'd1;
      for (int i = 0; i < 5; i++) begin
        trial = trial * 256'(cand);
      end
      for (int i = 0; i < 11; i++) begin
        trial = trial * 256'd255;
      end
      if (trial <= bound) begin
        v = cand;
      end
    end
    return v;
  endfunction

  // colour after optional brightness scaling, truncated
  function automatic logic [7:0] dim(input logic [7:0] colour, input logic [7:0] level);
    logic [GammaFrac+8:0] prod;
    prod = (GammaFrac + 9)'(colour) * (GammaFrac + 9)'(gamma_lut[level]);
    if (!gamma_on) begin
      return colour;
    end
    return prod[GammaFrac +: 8];
  endfunction

  // expected duty slots of one accepted request
  task automatic encode_request(input in_item_t rq);
    logic [23:0] grb;
    int          n;
    out_item_t   s;
    if (rq.kind == KIND_FRAME_END) begin
      n = int'(latch_slots);
      if (n < 1) begin
        n = 1;
      end
      if (n > int'(MAX_SLOTS)) begin
        n = int'(MAX_SLOTS);
      end
      for (int k = 0; k < n; k++) begin
        s.duty = 8'd0;
        s.last = (k == n - 1);
        duty_slots_due.push_back(s);
      end
      frame_ends_taken++;
    end else begin
      grb = {dim(rq.green, rq.brightness), dim(rq.red, rq.brightness),
             dim(rq.blue, rq.brightness)};
      for (int k = 0; k < 24; k++) begin
        s.duty = grb[23 - k] ? one_duty : zero_duty;
        s.last = (k == 23);
        duty_slots_due.push_back(s);
      end
    end
  endtask

  function automatic in_item_t mk_req(input logic kind, input logic [7:0] r, g, b, lvl);
    in_item_t rq;
    rq.kind = kind;
    rq.red = r;
    rq.green = g;
    rq.blue = b;
    rq.brightness = lvl;
    return rq;
  endfunction

  // one register write, bench copy follows
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_HIGH_DUTY:   one_duty = val;
      REG_LOW_DUTY:    zero_duty = val;
      REG_RESET_SLOTS: latch_slots = val[6:0];
      REG_BRIGHT_EN:   gamma_on = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] hi, lo, slots, input logic en);
    write_reg(REG_HIGH_DUTY, hi);
    write_reg(REG_LOW_DUTY, lo);
    write_reg(REG_RESET_SLOTS, slots);
    write_reg(REG_BRIGHT_EN, {7'd0, en});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every request to be taken and every slot to arrive
  task automatic drain();
    while (requests_pending.size() != 0 || start || duty_slots_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // request driver: holds start until taken, random gaps per idle_pct
  always @(posedge clk) begin
    logic     go;
    in_item_t taken;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken = requests_pending.pop_front();
        encode_request(taken);
        requests_taken++;
        go = 1'b1;
      end else if (!start) begin
        go = 1'b1;
      end
      if (go) begin
        if (requests_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          item  <= requests_pending[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // slot monitor: compare against the oldest expected slot
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_strobe) begin
      slots_checked++;
      if (duty_slots_due.size() == 0) begin
        faults++;
        if (faults <= MaxFaultReports) begin
          $display("slot with nothing expected: duty %0d last %0b", result.duty, result.last);
        end
      end else begin
        want = duty_slots_due.pop_front();
        if (result.duty !== want.duty || result.last !== want.last) begin
          faults++;
          if (faults <= MaxFaultReports) begin
            $display("slot mismatch at %0t: duty exp %0d got %0d, last exp %0b got %0b",
                     $realtime, want.duty, result.duty, want.last, result.last);
          end
        end
      end
    end
  end

  // stimulus and phase control
  initial begin
    in_item_t rq;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] slots;
    logic       en;
    for (int b = 0; b < 256; b++) begin
      gamma_lut[b] = gamma_point(b);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed requests on the reset register values
    @(negedge clk);
    idle_pct = 0;
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h01));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFE));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'hFF, 8'h00, 8'h00, 8'hFF));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'h00, 8'h00, 8'hFF, 8'hFF));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'hAA, 8'h55, 8'hAA, 8'h80));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'h55, 8'hAA, 8'h55, 8'hC8));
    requests_pending.push_back(mk_req(KIND_FRAME_END, 8'h00, 8'h00, 8'h00, 8'h00));
    requests_pending.push_back(mk_req(KIND_FRAME_END, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'h80, 8'h01, 8'h7F, 8'hFF));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'h01, 8'h80, 8'hFE, 8'h40));
    requests_pending.push_back(mk_req(KIND_PIXEL, 8'hC3, 8'h3C, 8'h99, 8'h7F));
    drain();

    // random phases, each on its own register setting, with gap rates of 0, 34 or 66 per cent
    for (int ph = 0; ph < RandPhases; ph++) begin
      hi = 8'($urandom_range(255));
      lo = 8'($urandom_range(255));
      slots = 8'($urandom_range(1, 64));
      en = 1'($urandom_range(1));
      case (ph)
        0: begin hi = 8'd255; lo = 8'd0;   slots = 8'd64;  en = 1'b1; end
        // zero slots after the 7 bit mask, treated as one
        1: begin hi = 8'd0;   lo = 8'd255; slots = 8'h80;  en = 1'b0; end
        2: begin slots = 8'd1; en = 1'b1; end
        // 127 saturates to the maximum
        3: begin slots = 8'hFF; en = 1'b0; end
        5: slots = 8'($urandom_range(255));
        default: ;
      endcase
      program_regs(hi, lo, slots, en);
      @(negedge clk);
      case (ph % 4)
        1: idle_pct = 66;
        3: idle_pct = 34;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < PhaseReqs; i++) begin
        rq.kind = ($urandom_range(3) == 0 || i == 0) ? KIND_FRAME_END : KIND_PIXEL;
        rq.red = 8'($urandom_range(255));
        rq.green = 8'($urandom_range(255));
        rq.blue = 8'($urandom_range(255));
        case ($urandom_range(7))
          0: rq.brightness = 8'h00;
          1: rq.brightness = 8'hFF;
          default: rq.brightness = 8'($urandom_range(255));
        endcase
        requests_pending.push_back(rq);
      end
      drain();
    end

    // let any stray slot show up
    repeat (8) @(posedge clk);
    $display("%0d requests (%0d frame ends) over %0d register settings, %0d slots checked",
             requests_taken, frame_ends_taken, RandPhases + 1, slots_checked);
    $display("gap rates 0/34/66 per cent, %0d faults, %0d slots outstanding",
             faults, duty_slots_due.size());
    if (faults == 0 && duty_slots_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("watchdog expired, %0d slots outstanding", duty_slots_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rgbenc_pkg.sv
hdl/rgbenc_scale.sv
hdl/rgbenc_ser.sv
hdl/rgb_led_serial_bit_encoder_unit.sv
verif/testbench.sv
